// ----- design/aes_sbox_boolean_circuit_core_defines.svh -----
// Assertion macros for the S-box gate network core.
// Taken in by the files that carry concurrent assertions; no other dependencies.
`ifndef AES_SBOX_BOOLEAN_CIRCUIT_CORE_DEFINES_SVH
`define AES_SBOX_BOOLEAN_CIRCUIT_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aes sbox core: implication violated");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aes sbox core: next-cycle check violated");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- design/aessbox_pkg.sv -----
// Shared types and constants of the S-box gate network pipeline.
// No dependencies; imported by every stage module and the top level.
package aessbox_pkg;

   localparam logic XNOR_ONE = 1'b1;

   typedef logic [7:0] byte_type;

   // top linear layer results, circuit bit 7 carried alongside
   typedef struct packed {
      logic        b7;
      logic [21:1] y;
   } lin_type;

   typedef struct packed {
      lin_type     lin;
      logic [24:21] t;
   } mid_type;

   typedef struct packed {
      lin_type lin;
      logic    t29;
      logic    t33;
      logic    t37;
      logic    t40;
      logic    t41;
      logic    t42;
      logic    t43;
      logic    t44;
      logic    t45;
   } inv_type;

endpackage

// ----- design/aessbox_pipe_reg.sv -----
// Elastic pipeline register with a valid bit and back-pressure.
// Generic in width; no package dependencies.
module aessbox_pipe_reg #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic             valid_ff;
   logic             valid_in;
   logic [WIDTH-1:0] data_ff;
   logic [WIDTH-1:0] data_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;
   assign data_in  = (in_valid && in_ready) ? in_data : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- design/aessbox_top_lin.sv -----
// Linear top layer of the S-box circuit: byte to the Y signals.
// Depends on aessbox_pkg for lin_type.
module aessbox_top_lin
   import aessbox_pkg::*;
(
   input  byte_type in_byte,
   output lin_type  lin
);

   logic [7:0]  b;
   logic [1:0]  t;
   logic [21:1] y;

   // circuit bit 0 is the byte's most significant bit
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         b[k] = in_byte[7-k];
      end
   end

   always_comb begin
      y[14] = b[3] ^ b[5];
      y[13] = b[0] ^ b[6];
      y[9]  = b[0] ^ b[3];
      y[8]  = b[0] ^ b[5];
      t[0]  = b[1] ^ b[2];
      y[1]  = t[0] ^ b[7];
      y[4]  = y[1] ^ b[3];
      y[12] = y[13] ^ y[14];
      y[2]  = y[1] ^ b[0];
      y[5]  = y[1] ^ b[6];
      y[3]  = y[5] ^ y[8];
      t[1]  = b[4] ^ y[12];
      y[15] = t[1] ^ b[5];
      y[20] = t[1] ^ b[1];
      y[6]  = y[15] ^ b[7];
      y[10] = y[15] ^ t[0];
      y[11] = y[20] ^ y[9];
      y[7]  = b[7] ^ y[11];
      y[17] = y[10] ^ y[11];
      y[19] = y[10] ^ y[8];
      y[16] = t[0] ^ y[11];
      y[21] = y[13] ^ y[16];
      y[18] = b[0] ^ y[16];
   end

   assign lin.b7 = b[7];
   assign lin.y  = y;

endmodule

// ----- design/aessbox_nl_mul.sv -----
// First nonlinear layer: GF(2^4) products feeding the inverter inputs.
// Depends on aessbox_pkg for lin_type and mid_type.
module aessbox_nl_mul
   import aessbox_pkg::*;
(
   input  lin_type lin,
   output mid_type mid
);

   logic [21:1] y;
   logic [24:2] t;

   assign y = lin.y;

   always_comb begin
      t[2]  = y[12] & y[15];
      t[3]  = y[3] & y[6];
      t[4]  = t[3] ^ t[2];
      t[5]  = y[4] & lin.b7;
      t[6]  = t[5] ^ t[2];
      t[7]  = y[13] & y[16];
      t[8]  = y[5] & y[1];
      t[9]  = t[8] ^ t[7];
      t[10] = y[2] & y[7];
      t[11] = t[10] ^ t[7];
      t[12] = y[9] & y[11];
      t[13] = y[14] & y[17];
      t[14] = t[13] ^ t[12];
      t[15] = y[8] & y[10];
      t[16] = t[15] ^ t[12];
      t[17] = t[4] ^ t[14];
      t[18] = t[6] ^ t[16];
      t[19] = t[9] ^ t[14];
      t[20] = t[11] ^ t[16];
      t[21] = t[17] ^ y[20];
      t[22] = t[18] ^ y[19];
      t[23] = t[19] ^ y[21];
      t[24] = t[20] ^ y[18];
   end

   assign mid.lin = lin;
   assign mid.t   = t[24:21];

endmodule

// ----- design/aessbox_gf_inv.sv -----
// GF(2^4) inversion core of the S-box circuit and its output sums.
// Depends on aessbox_pkg for mid_type and inv_type.
module aessbox_gf_inv
   import aessbox_pkg::*;
(
   input  mid_type mid,
   output inv_type inv
);

   logic [45:21] t;

   always_comb begin
      t[24:21] = mid.t;
      t[25] = t[21] ^ t[22];
      t[26] = t[21] & t[23];
      t[27] = t[24] ^ t[26];
      t[28] = t[25] & t[27];
      t[29] = t[28] ^ t[22];
      t[30] = t[23] ^ t[24];
      t[31] = t[22] ^ t[26];
      t[32] = t[31] & t[30];
      t[33] = t[32] ^ t[24];
      t[34] = t[23] ^ t[33];
      t[35] = t[27] ^ t[33];
      t[36] = t[24] & t[35];
      t[37] = t[36] ^ t[34];
      t[38] = t[27] ^ t[36];
      t[39] = t[29] & t[38];
      t[40] = t[25] ^ t[39];
      t[41] = t[40] ^ t[37];
      t[42] = t[29] ^ t[33];
      t[43] = t[29] ^ t[40];
      t[44] = t[33] ^ t[37];
      t[45] = t[42] ^ t[41];
   end

   assign inv.lin = mid.lin;
   assign inv.t29 = t[29];
   assign inv.t33 = t[33];
   assign inv.t37 = t[37];
   assign inv.t40 = t[40];
   assign inv.t41 = t[41];
   assign inv.t42 = t[42];
   assign inv.t43 = t[43];
   assign inv.t44 = t[44];
   assign inv.t45 = t[45];

endmodule

// ----- design/aessbox_bot_lin.sv -----
// Output products and linear bottom layer of the S-box circuit.
// Depends on aessbox_pkg for inv_type, byte_type and XNOR_ONE.
module aessbox_bot_lin
   import aessbox_pkg::*;
(
   input  inv_type  inv,
   output byte_type out_byte
);

   logic [21:1]  y;
   logic [17:0]  z;
   logic [67:46] t;
   logic [7:0]   s;

   assign y = inv.lin.y;

   always_comb begin
      z[0]  = inv.t44 & y[15];
      z[1]  = inv.t37 & y[6];
      z[2]  = inv.t33 & inv.lin.b7;
      z[3]  = inv.t43 & y[16];
      z[4]  = inv.t40 & y[1];
      z[5]  = inv.t29 & y[7];
      z[6]  = inv.t42 & y[11];
      z[7]  = inv.t45 & y[17];
      z[8]  = inv.t41 & y[10];
      z[9]  = inv.t44 & y[12];
      z[10] = inv.t37 & y[3];
      z[11] = inv.t33 & y[4];
      z[12] = inv.t43 & y[13];
      z[13] = inv.t40 & y[5];
      z[14] = inv.t29 & y[2];
      z[15] = inv.t42 & y[9];
      z[16] = inv.t45 & y[14];
      z[17] = inv.t41 & y[8];

      t[46] = z[15] ^ z[16];
      t[47] = z[10] ^ z[11];
      t[48] = z[5] ^ z[13];
      t[49] = z[9] ^ z[10];
      t[50] = z[2] ^ z[12];
      t[51] = z[2] ^ z[5];
      t[52] = z[7] ^ z[8];
      t[53] = z[0] ^ z[3];
      t[54] = z[6] ^ z[7];
      t[55] = z[16] ^ z[17];
      t[56] = z[12] ^ t[48];
      t[57] = t[50] ^ t[53];
      t[58] = z[4] ^ t[46];
      t[59] = z[3] ^ t[54];
      t[60] = t[46] ^ t[57];
      t[61] = z[14] ^ t[57];
      t[62] = t[52] ^ t[58];
      t[63] = t[49] ^ t[58];
      t[64] = z[4] ^ t[59];
      t[65] = t[61] ^ t[62];
      t[66] = z[1] ^ t[63];
      t[67] = t[64] ^ t[65];

      s[0] = t[59] ^ t[63];
      s[6] = XNOR_ONE ^ t[56] ^ t[62];
      s[7] = XNOR_ONE ^ t[48] ^ t[60];
      s[3] = t[53] ^ t[66];
      s[4] = t[51] ^ t[66];
      s[5] = t[47] ^ t[65];
      s[1] = XNOR_ONE ^ t[64] ^ s[3];
      s[2] = XNOR_ONE ^ t[55] ^ t[67];
   end

   // pack circuit bit 0 back as the most significant bit
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         out_byte[7-k] = s[k];
      end
   end

endmodule

// ----- design/aes_sbox_boolean_circuit_core.sv -----
// AES forward S-box as a four-stage pipelined Boyar-Peralta gate network.
// Path: a req word accepted into u_s1 passes u_s2, u_s3 and u_s4 to rsp_tvalid; back-pressure can stall it.
// Throughput: one word per cycle while rsp_tready holds high, set by the elastic register at the end of each stage.
// Reset: synchronous, active high; clears every stage valid bit, data registers keep state.
// Depends on aessbox_pkg, the stage modules and the assertion macro header.
`include "aes_sbox_boolean_circuit_core_defines.svh"
module aes_sbox_boolean_circuit_core
   import aessbox_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [7:0] out_byte
);

   lin_type  lin_comb;
   lin_type  s1_data;
   mid_type  mid_comb;
   mid_type  s2_data;
   inv_type  inv_comb;
   inv_type  s3_data;
   byte_type out_comb;

   logic s1_valid;
   logic s2_valid;
   logic s3_valid;
   logic s2_ready;
   logic s3_ready;
   logic s4_ready;

   aessbox_top_lin u_top_lin (
      .in_byte (req_tdata),
      .lin     (lin_comb)
   );

   aessbox_pipe_reg #(.WIDTH($bits(lin_type))) u_s1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (lin_comb),
      .out_valid (s1_valid),
      .out_ready (s2_ready),
      .out_data  (s1_data)
   );

   aessbox_nl_mul u_nl_mul (
      .lin (s1_data),
      .mid (mid_comb)
   );

   aessbox_pipe_reg #(.WIDTH($bits(mid_type))) u_s2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s2_ready),
      .in_data   (mid_comb),
      .out_valid (s2_valid),
      .out_ready (s3_ready),
      .out_data  (s2_data)
   );

   aessbox_gf_inv u_gf_inv (
      .mid (s2_data),
      .inv (inv_comb)
   );

   aessbox_pipe_reg #(.WIDTH($bits(inv_type))) u_s3 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s3_ready),
      .in_data   (inv_comb),
      .out_valid (s3_valid),
      .out_ready (s4_ready),
      .out_data  (s3_data)
   );

   aessbox_bot_lin u_bot_lin (
      .inv      (s3_data),
      .out_byte (out_comb)
   );

   aessbox_pipe_reg #(.WIDTH($bits(byte_type))) u_s4 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_ready  (s4_ready),
      .in_data   (out_comb),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

   // stall only with every stage full and the output held
   `ASSERT_IMPLY(a_stall_full, clock, reset, !req_tready, s1_valid && s2_valid && s3_valid && rsp_tvalid && !rsp_tready)
   // drop everything in flight on reset
   `ASSERT_IMPLY(a_reset_empty, clock, reset, $past(reset), !s1_valid && !s2_valid && !s3_valid && !rsp_tvalid)
   // hold a blocked stage three word
   `ASSERT_NEXT(a_s3_hold, clock, reset, s3_valid && !s4_ready, s3_valid && $stable(s3_data))

endmodule
